@@ rtl/lswc_pkg.sv @@
package lswc_pkg;

  // Default coordinate width of the input and result fields.
  localparam int COORD_BITS_DEF = 16;

  // Configuration port geometry: four 32-bit registers at byte addresses 0, 4, 8, 12.
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 4;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_t;

  // Window edges in the order in which an endpoint is tested against them.
  typedef enum logic [1:0] {
    EDGE_LEFT   = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_TOP    = 2'd3
  } edge_t;

  typedef enum logic {
    END_A = 1'b0,
    END_B = 1'b1
  } endp_t;

endpackage

@@ rtl/lswc_if.sv @@
interface lswc_seg_if import lswc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by;

  modport source (output valid, ax, ay, bx, by, input ready);
  modport sink (input valid, ax, ay, bx, by, output ready);
endinterface

interface lswc_res_if import lswc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         visible;
  logic signed [COORD_BITS-1:0] clipped_ax;
  logic signed [COORD_BITS-1:0] clipped_ay;
  logic signed [COORD_BITS-1:0] clipped_bx;
  logic signed [COORD_BITS-1:0] clipped_by;

  modport source (output valid, visible, clipped_ax, clipped_ay, clipped_bx, clipped_by,
                  input ready);
  modport sink (input valid, visible, clipped_ax, clipped_ay, clipped_bx, clipped_by,
                output ready);
endinterface

@@ rtl/lswc_step.sv @@
module lswc_step import lswc_pkg::*; #(
  parameter int    COORD_BITS = COORD_BITS_DEF,
  parameter endp_t ENDP       = END_A,
  parameter edge_t EDGE       = EDGE_LEFT,
  localparam int   G          = COORD_BITS + 2,
  localparam int   PW         = 1 + 4 * G
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] win_left,
  input  logic signed [COORD_BITS-1:0] win_bottom,
  input  logic signed [COORD_BITS-1:0] win_right,
  input  logic signed [COORD_BITS-1:0] win_top,
  input  logic                         in_v,
  input  logic [PW-1:0]                in_pts,
  output logic                         in_go,
  output logic                         out_v,
  output logic [PW-1:0]                out_pts,
  input  logic                         nxt_go
);

  localparam int W  = G + 1;
  localparam int NW = 2 * W;
  localparam int XW = NW + 1;
  localparam int QB = G + 1;
  localparam int NS = QB + 3;
  localparam int SW = G + 3;

  localparam logic signed [G-1:0]  GMAX = {1'b0, {(G-1){1'b1}}};
  localparam logic signed [G-1:0]  GMIN = {1'b1, {(G-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = SW'(GMAX);
  localparam logic signed [SW-1:0] SMIN = SW'(GMIN);

  localparam bit XAXIS    = (EDGE == EDGE_LEFT) || (EDGE == EDGE_RIGHT);
  localparam bit LOW_EDGE = (EDGE == EDGE_LEFT) || (EDGE == EDGE_BOTTOM);

  typedef struct packed {
    logic                keep;
    logic signed [G-1:0] ax;
    logic signed [G-1:0] ay;
    logic signed [G-1:0] bx;
    logic signed [G-1:0] by;
  } pts_t;

  typedef struct packed {
    logic                cond;
    logic                dz;
    logic                qneg;
    logic signed [G-1:0] old;
    logic [W-1:0]        fmag;
    logic [W-1:0]        gmag;
    logic [W-1:0]        dmag;
    logic [XW-1:0]       rem;
    logic [QB-1:0]       quo;
    logic                ovf;
  } wk_t;

  logic                v_r     [NS];
  pts_t                pts_r   [NS];
  pts_t                pts_nxt [NS];
  logic                go      [NS];
  logic                vin     [NS];
  logic                gsucc   [NS];
  wk_t                 wk_r    [NS-1];
  wk_t                 wk_nxt  [NS-1];
  wk_t                 wk0;
  pts_t                fin_pts;
  logic signed [G-1:0] edge_g;

  always_comb begin
    unique case (EDGE)
      EDGE_LEFT:   edge_g = G'(win_left);
      EDGE_RIGHT:  edge_g = G'(win_right);
      EDGE_BOTTOM: edge_g = G'(win_bottom);
      EDGE_TOP:    edge_g = G'(win_top);
      default:     edge_g = G'(win_left);
    endcase
  end

  // Setup: edge test, numerator factors and denominator with their signs.
  always_comb begin
    pts_t                p0;
    logic signed [G-1:0] px, py, qx, qy, pc, po, qc, qo;
    logic signed [W-1:0] den, f, g;
    p0 = pts_t'(in_pts);
    if (ENDP == END_A) begin
      px = p0.ax; py = p0.ay; qx = p0.bx; qy = p0.by;
    end else begin
      px = p0.bx; py = p0.by; qx = p0.ax; qy = p0.ay;
    end
    if (XAXIS) begin
      pc = px; po = py; qc = qx; qo = qy;
    end else begin
      pc = py; po = px; qc = qy; qo = qx;
    end
    den = W'(qc) - W'(pc);
    f   = W'(edge_g) - W'(pc);
    g   = W'(qo) - W'(po);
    wk0      = '0;
    wk0.cond = LOW_EDGE ? (pc < edge_g) : (pc > edge_g);
    wk0.dz   = (den == '0);
    wk0.qneg = f[W-1] ^ g[W-1] ^ den[W-1];
    wk0.old  = po;
    wk0.fmag = f[W-1] ? -f : f;
    wk0.gmag = g[W-1] ? -g : g;
    wk0.dmag = den[W-1] ? -den : den;
  end

  // Product stage, then one quotient bit per stage, most significant first.
  always_comb begin
    logic [NW-1:0] prod;
    logic [XW-1:0] sh;
    wk_nxt[0] = wk0;
    prod = NW'(wk_r[0].fmag) * NW'(wk_r[0].gmag);
    wk_nxt[1]     = wk_r[0];
    wk_nxt[1].rem = {1'b0, prod};
    for (int j = 2; j < QB + 2; j++) begin
      wk_nxt[j] = wk_r[j-1];
      sh = XW'(wk_r[j-1].dmag) << (QB + 1 - j);
      if (j == 2) begin
        wk_nxt[j].ovf = wk_r[j-1].rem >= (XW'(wk_r[j-1].dmag) << QB);
      end
      if (wk_r[j-1].rem >= sh) begin
        wk_nxt[j].rem = wk_r[j-1].rem - sh;
        wk_nxt[j].quo[QB + 1 - j] = 1'b1;
      end
    end
  end

  // Finish: signed quotient plus old coordinate, truncation toward zero, saturation.
  always_comb begin
    wk_t                  w;
    pts_t                 p;
    logic signed [SW-1:0] t, s;
    logic signed [G-1:0]  res;
    w = wk_r[NS-2];
    p = pts_r[NS-2];
    t = SW'(w.quo);
    if (w.qneg) begin
      t = -t;
    end
    s = SW'(w.old) + t;
    if (w.rem != '0) begin
      if (w.qneg && (s > 0)) begin
        s = s - SW'(1);
      end else if (!w.qneg && (s < 0)) begin
        s = s + SW'(1);
      end
    end
    if (w.ovf) begin
      res = w.qneg ? GMIN : GMAX;
    end else if (s > SMAX) begin
      res = GMAX;
    end else if (s < SMIN) begin
      res = GMIN;
    end else begin
      res = s[G-1:0];
    end
    fin_pts = p;
    if (w.cond) begin
      if (ENDP == END_A) begin
        if (XAXIS) begin
          fin_pts.ax = edge_g;
          if (!w.dz) fin_pts.ay = res;
        end else begin
          fin_pts.ay = edge_g;
          if (!w.dz) fin_pts.ax = res;
        end
      end else begin
        if (XAXIS) begin
          fin_pts.bx = edge_g;
          if (!w.dz) fin_pts.by = res;
        end else begin
          fin_pts.by = edge_g;
          if (!w.dz) fin_pts.bx = res;
        end
      end
    end
  end

  // Each stage loads when the pipe moves or when it is empty, so bubbles close up.
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      go[k] = en || !v_r[k];
    end
    vin[0]     = in_v;
    pts_nxt[0] = pts_t'(in_pts);
    for (int k = 1; k < NS; k++) begin
      vin[k]     = v_r[k-1];
      pts_nxt[k] = pts_r[k-1];
    end
    pts_nxt[NS-1] = fin_pts;
    for (int k = 0; k < NS - 1; k++) begin
      gsucc[k] = go[k+1];
    end
    gsucc[NS-1] = nxt_go;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (go[k]) begin
        v_r[k] <= vin[k];
      end else if (gsucc[k]) begin
        v_r[k] <= 1'b0;
      end
      if (go[k]) begin
        pts_r[k] <= pts_nxt[k];
      end
    end
    for (int k = 0; k < NS - 1; k++) begin
      if (go[k]) begin
        wk_r[k] <= wk_nxt[k];
      end
    end
  end

  assign in_go   = go[0];
  assign out_v   = v_r[NS-1];
  assign out_pts = pts_r[NS-1];

endmodule

@@ rtl/line_segment_window_clipper_top.sv @@
// Line segment window clipper.
// A segment (ax, ay, bx, by) enters on in_seg and is accepted when valid and
// ready are both high. One result item per segment leaves on out_res: visible
// with the clipped endpoints, or visible low with all coordinates zero when
// the segment misses the window.
// The window edges are four APB registers (left, bottom, right, top at byte
// addresses 0, 4, 8 and 12); write them only while no segment is in flight.
// A single pipeline: an input register, a step per endpoint and edge (A and
// then B against left, right, bottom, top) and an output register. Each step
// runs a setup stage, a multiply stage, one restoring-division stage per
// quotient bit and a finishing stage, COORD_BITS+6 stages in all.
// Throughput is one segment per cycle while the receiver keeps taking results.
// When the receiver stalls, the pipeline holds its contents, but empty stages
// keep filling, so new segments are still taken until every stage is full.
// Reset (synchronous, active low) empties the pipeline and sets every window
// register to zero.
module line_segment_window_clipper_top import lswc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  lswc_seg_if.sink           in_seg,
  lswc_res_if.source         out_res,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int G     = COORD_BITS + 2;
  localparam int PW    = 1 + 4 * G;
  localparam int NSTEP = 8;

  typedef struct packed {
    logic                keep;
    logic signed [G-1:0] ax;
    logic signed [G-1:0] ay;
    logic signed [G-1:0] bx;
    logic signed [G-1:0] by;
  } pts_t;

  logic signed [COORD_BITS-1:0] win_left_r, win_bottom_r, win_right_r, win_top_r;

  logic          en;
  logic          go_in;
  logic          step_v   [NSTEP+1];
  logic [PW-1:0] step_pts [NSTEP+1];
  logic          step_go  [NSTEP+1];

  logic                         in_v_r;
  pts_t                         in_pts_r;
  pts_t                         in_pts_nxt;
  pts_t                         last_pts;
  logic                         vis_nxt;
  logic                         out_v_r;
  logic                         out_vis_r;
  logic signed [COORD_BITS-1:0] out_ax_r, out_ay_r, out_bx_r, out_by_r;

  // Bit 3 above, bit 2 below, bit 1 right, bit 0 left.
  function automatic logic [3:0] outcode(input logic signed [G-1:0] x,
                                         input logic signed [G-1:0] y);
    logic [3:0] c;
    c[3] = y > G'(win_top_r);
    c[2] = y < G'(win_bottom_r);
    c[1] = x > G'(win_right_r);
    c[0] = x < G'(win_left_r);
    return c;
  endfunction

  // Configuration registers.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= '0;
      win_bottom_r <= '0;
      win_right_r  <= '0;
      win_top_r    <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (reg_idx_t'(cfg_paddr[CFG_AW-1:2]))
        REG_LEFT:   win_left_r   <= cfg_pwdata[COORD_BITS-1:0];
        REG_BOTTOM: win_bottom_r <= cfg_pwdata[COORD_BITS-1:0];
        REG_RIGHT:  win_right_r  <= cfg_pwdata[COORD_BITS-1:0];
        REG_TOP:    win_top_r    <= cfg_pwdata[COORD_BITS-1:0];
        default:    win_left_r   <= win_left_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[CFG_AW-1:2]))
      REG_LEFT:   cfg_prdata = CFG_DW'(win_left_r);
      REG_BOTTOM: cfg_prdata = CFG_DW'(win_bottom_r);
      REG_RIGHT:  cfg_prdata = CFG_DW'(win_right_r);
      REG_TOP:    cfg_prdata = CFG_DW'(win_top_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // The whole pipeline moves when the output register is free or being read.
  assign en    = out_res.ready || !out_v_r;
  assign go_in = en || !in_v_r;
  assign in_seg.ready = go_in;

  // Input stage: widen the endpoints and do the trivial reject test.
  always_comb begin
    in_pts_nxt.ax   = G'(in_seg.ax);
    in_pts_nxt.ay   = G'(in_seg.ay);
    in_pts_nxt.bx   = G'(in_seg.bx);
    in_pts_nxt.by   = G'(in_seg.by);
    in_pts_nxt.keep = (outcode(in_pts_nxt.ax, in_pts_nxt.ay) &
                       outcode(in_pts_nxt.bx, in_pts_nxt.by)) == 4'b0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (go_in) begin
      in_v_r <= in_seg.valid;
    end else if (step_go[0]) begin
      in_v_r <= 1'b0;
    end
    if (go_in) begin
      in_pts_r <= in_pts_nxt;
    end
  end

  assign step_v[0]       = in_v_r;
  assign step_pts[0]     = in_pts_r;
  assign step_go[NSTEP]  = en;

  // Endpoint A against each window edge in turn, then endpoint B against them along the line to the clipped A.
  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    lswc_step #(
      .COORD_BITS (COORD_BITS),
      .ENDP       ((s < NSTEP / 2) ? END_A : END_B),
      .EDGE       (edge_t'(2'(s % 4)))
    ) u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .win_left   (win_left_r),
      .win_bottom (win_bottom_r),
      .win_right  (win_right_r),
      .win_top    (win_top_r),
      .in_v       (step_v[s]),
      .in_pts     (step_pts[s]),
      .in_go      (step_go[s]),
      .out_v      (step_v[s+1]),
      .out_pts    (step_pts[s+1]),
      .nxt_go     (step_go[s+1])
    );
  end

  // Output stage: final inside test; a rejected segment reads as all zeros.
  always_comb begin
    last_pts = pts_t'(step_pts[NSTEP]);
    vis_nxt  = last_pts.keep &&
               (outcode(last_pts.ax, last_pts.ay) == 4'b0000) &&
               (outcode(last_pts.bx, last_pts.by) == 4'b0000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= step_v[NSTEP];
    end
    if (en) begin
      out_vis_r <= vis_nxt;
      out_ax_r  <= vis_nxt ? last_pts.ax[COORD_BITS-1:0] : '0;
      out_ay_r  <= vis_nxt ? last_pts.ay[COORD_BITS-1:0] : '0;
      out_bx_r  <= vis_nxt ? last_pts.bx[COORD_BITS-1:0] : '0;
      out_by_r  <= vis_nxt ? last_pts.by[COORD_BITS-1:0] : '0;
    end
  end

  assign out_res.valid      = out_v_r;
  assign out_res.visible    = out_vis_r;
  assign out_res.clipped_ax = out_ax_r;
  assign out_res.clipped_ay = out_ay_r;
  assign out_res.clipped_bx = out_bx_r;
  assign out_res.clipped_by = out_by_r;

`ifndef SYNTHESIS
  // A rejected segment carries zero coordinates.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.visible |->
      out_res.clipped_ax == '0 && out_res.clipped_ay == '0 &&
      out_res.clipped_bx == '0 && out_res.clipped_by == '0)
    else $error("rejected segment with nonzero coordinates");

  // With the output register empty, the pipeline is moving and takes input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_seg.ready)
    else $error("input stalled while output register is empty");
`endif

endmodule
